>>> design/gmcp_pkg.sv
// Shared types, constants and helpers for the grid minimum cost path block.
`default_nettype none

package gmcp_pkg;

  localparam int GRID_DIM_DEF = 16;
  localparam int COORD_W      = 4;
  localparam int COST_W       = 16;
  localparam int SUM_W        = 24;
  localparam int DATA_W       = 24;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic take_item;  // input item accepted this cycle
    logic walk;       // issue reads for the current cell and advance
    logic load_out;   // move result into the output register
  } ctl_cmd_t;

  typedef struct packed {
    logic is_query;
    logic in_range;
    logic last_cell;
    logic out_free;
  } ctl_stat_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0]  a,
                                               input logic [COST_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W-COST_W+1){1'b0}}, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> design/gmcp_ctrl.sv
// Controller state machine: sequences loads, the table walk and result handoff.
`default_nettype none

module gmcp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire gmcp_pkg::ctl_stat_t  stat,
  output gmcp_pkg::ctl_cmd_t        cmd
);
  import gmcp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && stat.is_query) begin
          state_next = stat.in_range ? ST_WALK : ST_HOLD;
        end
      end
      ST_WALK: begin
        if (stat.last_cell) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: state_next = ST_HOLD;
      ST_HOLD: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        s_tready      = 1'b1;
        cmd.take_item = s_tvalid;
      end
      ST_WALK:  cmd.walk = 1'b1;
      ST_FLUSH: cmd      = '0;
      ST_HOLD:  cmd.load_out = stat.out_free;
      default:  cmd      = '0;
    endcase
  end

  a_load_needs_slot : assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded while output register busy");

  a_last_to_flush : assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && stat.last_cell) |=> state == ST_FLUSH)
    else $error("walk did not end after the target cell");

  a_hold_waits : assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD && !stat.out_free) |=> state == ST_HOLD)
    else $error("left hold while output register busy");

endmodule

`default_nettype wire

>>> design/gmcp_datapath.sv
// Datapath: cost memory, row sum memory, walk counters, cell update and output register.
`default_nettype none

module gmcp_datapath #(
  parameter int GRID_DIM = gmcp_pkg::GRID_DIM_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [gmcp_pkg::DATA_W-1:0]   s_tdata,
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [gmcp_pkg::DATA_W-1:0]        m_tdata,
  output logic                               m_tuser,
  input  wire gmcp_pkg::ctl_cmd_t            cmd,
  output gmcp_pkg::ctl_stat_t                stat
);
  import gmcp_pkg::*;

  localparam int          IW    = $clog2(GRID_DIM);
  localparam int          AW    = $clog2(GRID_DIM * GRID_DIM);
  localparam int unsigned DIM_U = GRID_DIM;

  // input item fields
  logic [COORD_W-1:0] row, col;
  logic [COST_W-1:0]  cell_cost;
  logic               in_range;
  logic [AW-1:0]      ld_addr;

  assign row       = s_tdata[COORD_W-1:0];
  assign col       = s_tdata[2*COORD_W-1:COORD_W];
  assign cell_cost = s_tdata[2*COORD_W+COST_W-1:2*COORD_W];
  assign in_range  = (32'(row) < DIM_U) && (32'(col) < DIM_U);
  assign ld_addr   = AW'(row) * AW'(GRID_DIM) + AW'(col);

  logic [COST_W-1:0] cost_grid [GRID_DIM*GRID_DIM];
  logic [SUM_W-1:0]  row_sums  [GRID_DIM];

  // walk state
  logic [IW-1:0] tr, tc, ci, cj;
  logic [AW-1:0] addr, row_base;
  logic          err;
  logic          end_of_row, tc_zero;

  assign end_of_row = (cj == tc);
  assign tc_zero    = (tc == '0);

  // second stage: registered reads and cell position flags
  logic              b_valid, b_i0, b_j0;
  logic [IW-1:0]     b_j;
  logic [COST_W-1:0] cost_q;
  logic [SUM_W-1:0]  up_q;
  logic [SUM_W-1:0]  left, up_eff, m_sum, v;

  always_ff @(posedge clk) begin
    if (cmd.take_item && s_tuser == CMD_LOAD && in_range) begin
      cost_grid[ld_addr] <= cell_cost;
    end
    if (cmd.walk) begin
      cost_q <= cost_grid[addr];
      up_q   <= row_sums[cj];
    end
    if (b_valid) begin
      row_sums[b_j] <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ci       <= '0;
      cj       <= '0;
      addr     <= '0;
      row_base <= '0;
      err      <= 1'b0;
      b_valid  <= 1'b0;
      left     <= '0;
    end else begin
      b_valid <= cmd.walk;
      if (cmd.take_item && s_tuser == CMD_QUERY) begin
        ci       <= '0;
        cj       <= '0;
        addr     <= '0;
        row_base <= '0;
        err      <= !in_range;
        tr       <= IW'(row);
        tc       <= IW'(col);
      end else if (cmd.walk) begin
        b_i0 <= (ci == '0);
        b_j0 <= (cj == '0);
        b_j  <= cj;
        if (end_of_row) begin
          ci       <= ci + 1'b1;
          cj       <= '0;
          row_base <= row_base + AW'(GRID_DIM);
          addr     <= row_base + AW'(GRID_DIM);
        end else begin
          cj   <= cj + 1'b1;
          addr <= addr + 1'b1;
        end
      end
      if (b_valid) begin
        left <= v;
      end
    end
  end

  // With a one-column target the cell above was computed in the previous
  // cycle and its memory write is not yet visible; take it from left instead.
  always_comb begin
    up_eff = tc_zero ? left : up_q;
    if (b_i0) begin
      m_sum = left;
    end else if (b_j0) begin
      m_sum = up_eff;
    end else begin
      m_sum = (up_eff < left) ? up_eff : left;
    end
    v = (b_i0 && b_j0) ? {{(SUM_W-COST_W){1'b0}}, cost_q} : sat_add(m_sum, cost_q);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= err ? '0 : DATA_W'(left);
      m_tuser <= err ? STATUS_RANGE : STATUS_OK;
    end
  end

  always_comb begin
    stat.is_query  = (s_tuser == CMD_QUERY);
    stat.in_range  = in_range;
    stat.last_cell = (ci == tr) && end_of_row;
    stat.out_free  = !m_tvalid || m_tready;
  end

  a_walk_in_grid : assert property (@(posedge clk) disable iff (rst)
    cmd.walk |-> (!err && ci <= tr && cj <= tc))
    else $error("walk outside target rectangle");

  a_err_zero_cost : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STATUS_RANGE) |-> m_tdata == '0)
    else $error("range error result carries a cost");

  a_stage_follows_walk : assert property (@(posedge clk) disable iff (rst)
    (cmd.walk && end_of_row) |=> (cj == '0 && b_valid))
    else $error("column counter did not wrap at row end");

endmodule

`default_nettype wire

>>> design/grid_min_cost_path.sv
// Top level of the grid minimum cost path block: controller plus datapath.
//
//  channel   dir  tdata                                   tuser
//  s_*       in   [3:0] row, [7:4] col, [23:8] cell_cost  command (0 load, 1 query)
//  m_*       out  [23:0] path_cost                        status (0 ok, 1 range)
//
// A query walks (row+1)*(col+1) cells, one cell per cycle through the cost
// memory read port; then the flush state finishes the last cell and the hold
// state loads the output register once it is free. An out-of-range query
// skips the walk and goes straight to the hold state with its error item.
// rst is synchronous; no memory clearing pass. The output register lets loads
// proceed while a result waits; a finished query holds until the register is free.
`default_nettype none

module grid_min_cost_path #(
  parameter int GRID_DIM = gmcp_pkg::GRID_DIM_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [gmcp_pkg::DATA_W-1:0]  s_tdata,   // row, col, cell_cost
  input  wire logic                         s_tuser,   // command
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [gmcp_pkg::DATA_W-1:0]       m_tdata,   // path_cost
  output logic                              m_tuser    // status
);
  import gmcp_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  gmcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gmcp_datapath #(
    .GRID_DIM (GRID_DIM)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

`default_nettype wire
